[sv/prd_pkg.sv]
// Shared constants and types for the pulse rate detector.
package prd_pkg;

  localparam int WINDOW     = 512;
  localparam int WIN_AW     = $clog2(WINDOW);
  localparam int FILL_W     = $clog2(WINDOW + 1);
  localparam int SAMPLE_W   = 12;
  localparam int SUM_W      = SAMPLE_W + WIN_AW;
  localparam int AVG_SHIFT  = WIN_AW;
  localparam int TS_W       = 52;
  localparam int THR_W      = 10;
  localparam int LEVEL_W    = SAMPLE_W + THR_W;
  localparam int MIN_W      = 32;
  localparam int TICK_W     = 30;
  localparam int BPM_W      = 12;
  localparam int NUM_W      = TICK_W + 10;
  localparam int DIV_STEPS  = NUM_W;
  localparam int DCNT_W     = $clog2(DIV_STEPS);
  localparam int ALU_W      = TS_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTV  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BPM_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BPM_HIGH  = 3'd4;

  localparam logic [THR_W-1:0]  THRESHOLD_RST = 10'd448;
  localparam logic [MIN_W-1:0]  MIN_INTV_RST  = 32'd133200000;
  localparam logic [TICK_W-1:0] TICK_RATE_RST = 30'd333000000;
  localparam logic [BPM_W-1:0]  BPM_LOW_RST   = 12'd640;
  localparam logic [BPM_W-1:0]  BPM_HIGH_RST  = 12'd2560;
  localparam logic [BPM_W-1:0]  BPM_SAT       = 12'hFFF;

  typedef logic [TS_W-1:0]     ts_t;
  typedef logic [SAMPLE_W-1:0] sample_t;

endpackage

[sv/pulse_rate_detector_core.sv]
// Pulse rate detector: sliding-window average, threshold edge detect, iterative rate divider.
// Other channels go straight to the result; channel 0 updates the window, and once it is full
//   tests for an edge; an edge past the minimum interval runs the 40-step divider (shared add/sub).
// Throughput: one word at a time; the next word is taken the cycle after the result is loaded.
// Reset clears control state, window sum, fill count, pointers and registers to defaults;
//   the window store is not cleared and its read data is only used once it has been filled.
module pulse_rate_detector_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_chan,
  input  logic [prd_pkg::SAMPLE_W-1:0]    in_sample,
  input  logic [prd_pkg::TS_W-1:0]        in_timestamp,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_window_full,
  output logic [prd_pkg::SAMPLE_W-1:0]    out_average,
  output logic                            out_rising_edge,
  output logic                            out_beat_valid,
  output logic [prd_pkg::BPM_W-1:0]       out_bpm_q4,
  output logic [prd_pkg::TS_W-1:0]        out_interval_ticks,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [prd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [prd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SUB  = 4'd1;
  localparam logic [3:0] S_ADD  = 4'd2;
  localparam logic [3:0] S_AVG  = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_CMP  = 4'd5;
  localparam logic [3:0] S_MINC = 4'd6;
  localparam logic [3:0] S_NUM  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0] state_r, state_nxt;

  // configuration
  logic [prd_pkg::THR_W-1:0]  thr_r;
  logic [prd_pkg::MIN_W-1:0]  min_r;
  logic [prd_pkg::TICK_W-1:0] tick_r;
  logic [prd_pkg::BPM_W-1:0]  low_r;
  logic [prd_pkg::BPM_W-1:0]  high_r;

  // window state
  prd_pkg::sample_t                mem [prd_pkg::WINDOW];
  prd_pkg::sample_t                rd_data_r;
  logic [prd_pkg::SUM_W-1:0]       sum_r;
  logic [prd_pkg::FILL_W-1:0]      fill_r;
  logic [prd_pkg::WIN_AW-1:0]      wp_r;
  prd_pkg::sample_t                prev_r;
  prd_pkg::ts_t                    last_r;
  logic                            seen_r;

  // working registers
  prd_pkg::sample_t                s_r;
  prd_pkg::ts_t                    ts_r;
  logic                            full_r;
  prd_pkg::sample_t                avg_r;
  logic [prd_pkg::LEVEL_W-1:0]     level_r;
  logic                            edge_r;
  logic                            valid_r;
  logic [prd_pkg::BPM_W-1:0]       bpm_r;
  prd_pkg::ts_t                    intv_r;
  logic [prd_pkg::NUM_W-1:0]       q_r;
  prd_pkg::ts_t                    rem_r;
  logic [prd_pkg::DCNT_W-1:0]      dcnt_r;

  logic                            out_valid_r;

  // shared add/subtract unit
  logic [prd_pkg::ALU_W-1:0] alu_a, alu_b, alu_y;
  logic                      alu_sub;

  logic                      in_acc, out_free, win_full;
  logic [prd_pkg::SUM_W-1:0] avg_wide;
  logic [prd_pkg::LEVEL_W-1:0] s_scaled, p_scaled;
  logic                      edge_hit;

  assign in_acc    = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;
  assign win_full  = (fill_r == prd_pkg::FILL_W'(prd_pkg::WINDOW));
  assign avg_wide  = sum_r >> prd_pkg::AVG_SHIFT;
  assign s_scaled  = prd_pkg::LEVEL_W'({s_r, 8'b0});
  assign p_scaled  = prd_pkg::LEVEL_W'({prev_r, 8'b0});
  assign edge_hit  = (s_scaled > level_r) && (p_scaled < level_r);

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    case (state_r)
      S_SUB: begin
        alu_a = prd_pkg::ALU_W'(sum_r);
        alu_b = prd_pkg::ALU_W'(rd_data_r);
      end
      S_ADD: begin
        alu_a   = prd_pkg::ALU_W'(sum_r);
        alu_b   = prd_pkg::ALU_W'(s_r);
        alu_sub = 1'b0;
      end
      S_CMP: begin
        alu_a = prd_pkg::ALU_W'(ts_r);
        alu_b = prd_pkg::ALU_W'(last_r);
      end
      S_MINC: begin
        alu_a = prd_pkg::ALU_W'(min_r);
        alu_b = prd_pkg::ALU_W'(intv_r);
      end
      S_NUM: begin
        alu_a = prd_pkg::ALU_W'({tick_r, 10'b0});
        alu_b = prd_pkg::ALU_W'({tick_r, 6'b0});
      end
      S_DIV: begin
        alu_a = prd_pkg::ALU_W'({rem_r, q_r[prd_pkg::NUM_W-1]});
        alu_b = prd_pkg::ALU_W'(intv_r);
      end
      default: begin
        alu_sub = 1'b1;
      end
    endcase
    alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  end

  // window store: read at accept, write during the sum update
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= mem[wp_r];
    end
    if (state_r == S_SUB) begin
      mem[wp_r] <= s_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = (in_chan == 2'd0) ? S_SUB : S_DONE;
      S_SUB:  state_nxt = S_ADD;
      S_ADD:  state_nxt = S_AVG;
      S_AVG:  state_nxt = win_full ? S_MUL : S_DONE;
      S_MUL:  state_nxt = S_CMP;
      S_CMP:  state_nxt = (edge_hit && seen_r) ? S_MINC : S_DONE;
      S_MINC: state_nxt = alu_y[prd_pkg::ALU_W-1] ? S_NUM : S_DONE;
      S_NUM:  state_nxt = S_DIV;
      S_DIV:  if (dcnt_r == prd_pkg::DCNT_W'(prd_pkg::DIV_STEPS - 1)) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= prd_pkg::THRESHOLD_RST;
      min_r       <= prd_pkg::MIN_INTV_RST;
      tick_r      <= prd_pkg::TICK_RATE_RST;
      low_r       <= prd_pkg::BPM_LOW_RST;
      high_r      <= prd_pkg::BPM_HIGH_RST;
      sum_r       <= '0;
      fill_r      <= '0;
      wp_r        <= '0;
      prev_r      <= '0;
      last_r      <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        case (cfg_index)
          prd_pkg::REG_THRESHOLD: thr_r  <= cfg_data[prd_pkg::THR_W-1:0];
          prd_pkg::REG_MIN_INTV:  min_r  <= cfg_data[prd_pkg::MIN_W-1:0];
          prd_pkg::REG_TICK_RATE: tick_r <= cfg_data[prd_pkg::TICK_W-1:0];
          prd_pkg::REG_BPM_LOW:   low_r  <= cfg_data[prd_pkg::BPM_W-1:0];
          prd_pkg::REG_BPM_HIGH:  high_r <= cfg_data[prd_pkg::BPM_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_SUB: begin
          if (win_full) begin
            sum_r <= alu_y[prd_pkg::SUM_W-1:0];
          end else begin
            fill_r <= fill_r + 1'b1;
          end
        end
        S_ADD: begin
          sum_r <= alu_y[prd_pkg::SUM_W-1:0];
          wp_r  <= (wp_r == prd_pkg::WIN_AW'(prd_pkg::WINDOW - 1)) ? '0 : wp_r + 1'b1;
        end
        S_AVG: begin
          if (!win_full) begin
            prev_r <= s_r;
          end
        end
        S_CMP: begin
          prev_r <= s_r;
          if (edge_hit) begin
            last_r <= ts_r;
            seen_r <= 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          s_r     <= in_sample;
          ts_r    <= in_timestamp;
          full_r  <= win_full;
          avg_r   <= win_full ? avg_wide[prd_pkg::SAMPLE_W-1:0] : '0;
          edge_r  <= 1'b0;
          valid_r <= 1'b0;
          bpm_r   <= '0;
          intv_r  <= '0;
        end
      end
      S_AVG: begin
        full_r <= win_full;
        avg_r  <= win_full ? avg_wide[prd_pkg::SAMPLE_W-1:0] : '0;
      end
      S_MUL: begin
        level_r <= prd_pkg::LEVEL_W'(avg_r) * prd_pkg::LEVEL_W'(thr_r);
      end
      S_CMP: begin
        edge_r <= edge_hit;
        if (edge_hit && seen_r) begin
          intv_r <= alu_y[prd_pkg::TS_W-1:0];
        end
      end
      S_NUM: begin
        q_r    <= alu_y[prd_pkg::NUM_W-1:0];
        rem_r  <= '0;
        dcnt_r <= '0;
      end
      S_DIV: begin
        dcnt_r <= dcnt_r + 1'b1;
        if (alu_y[prd_pkg::ALU_W-1]) begin
          rem_r <= {rem_r[prd_pkg::TS_W-2:0], q_r[prd_pkg::NUM_W-1]};
          q_r   <= {q_r[prd_pkg::NUM_W-2:0], 1'b0};
        end else begin
          rem_r <= alu_y[prd_pkg::TS_W-1:0];
          q_r   <= {q_r[prd_pkg::NUM_W-2:0], 1'b1};
        end
      end
      S_FIN: begin
        // low < rate < high: quotient above low, or equal with a remainder, and below high
        if (((q_r > prd_pkg::NUM_W'(low_r)) ||
             ((q_r == prd_pkg::NUM_W'(low_r)) && (rem_r != '0))) &&
            (q_r < prd_pkg::NUM_W'(high_r))) begin
          valid_r <= 1'b1;
          bpm_r   <= (q_r > prd_pkg::NUM_W'(prd_pkg::BPM_SAT)) ? prd_pkg::BPM_SAT
                                                               : q_r[prd_pkg::BPM_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // result word
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_window_full    <= full_r;
      out_average        <= avg_r;
      out_rising_edge    <= edge_r;
      out_beat_valid     <= valid_r;
      out_bpm_q4         <= bpm_r;
      out_interval_ticks <= intv_r;
    end
  end

endmodule
